// ===== hw/rtl/sce_pkg.sv =====
// ----------------------------------------------------------------------------
// sce_pkg
// Shared types and constants of the subset convolution engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sce_pkg;

    localparam int SCE_MAX_BITS   = 8;
    localparam int SCE_VALUE_BITS = 16;
    localparam int SET_BITS_W     = 4;
    localparam int CFG_INDEX_W    = 4;
    localparam int CFG_DATA_W     = 8;
    localparam int ACC_W          = 64;
    localparam int HALF_W         = 32;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_COMPUTE = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_SET_BITS     = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_PRODUCT_MODE = CFG_INDEX_W'(1);

    localparam logic [1:0] ARR_F = 2'd0;
    localparam logic [1:0] ARR_G = 2'd1;
    localparam logic [1:0] ARR_P = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_INIT,
        ST_ZETA,
        ST_MUL,
        ST_GATHER
    } state_t;

    typedef enum logic [1:0] {
        MUL_LL,
        MUL_LH,
        MUL_HL
    } mul_part_t;

    typedef struct packed {
        logic      sub;
        mul_part_t part;
    } alu_ctrl_t;

endpackage

// ===== hw/rtl/sce_if.sv =====
// ----------------------------------------------------------------------------
// sce_if
// Valid/ready channels of the subset convolution engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sce_in_if import sce_pkg::*; #(
    parameter int SUBSET_BITS = SCE_MAX_BITS,
    parameter int VALUE_BITS  = SCE_VALUE_BITS
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    operation;
    logic [SUBSET_BITS-1:0]        subset;
    logic signed [VALUE_BITS-1:0]  f_value;
    logic signed [VALUE_BITS-1:0]  g_value;

    modport source (output valid, operation, subset, f_value, g_value, input ready);
    modport sink   (input valid, operation, subset, f_value, g_value, output ready);
endinterface

interface sce_out_if import sce_pkg::*; #(
    parameter int SUBSET_BITS = SCE_MAX_BITS
);
    logic                      valid;
    logic                      ready;
    logic [SUBSET_BITS-1:0]    out_subset;
    logic signed [ACC_W-1:0]   value;

    modport source (output valid, out_subset, value, input ready);
    modport sink   (input valid, out_subset, value, output ready);
endinterface

interface sce_cfg_if import sce_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [CFG_INDEX_W-1:0]  index;
    logic [CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/sce_alu.sv =====
// ----------------------------------------------------------------------------
// sce_alu
// Shared 64-bit adder/subtractor and registered 32x32 partial multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sce_alu import sce_pkg::*; (
    input  logic             clk,
    input  alu_ctrl_t        ctrl,
    input  logic [ACC_W-1:0] add_a,
    input  logic [ACC_W-1:0] add_b,
    input  logic [ACC_W-1:0] mul_x,
    input  logic [ACC_W-1:0] mul_y,
    output logic [ACC_W-1:0] sum,
    output logic [ACC_W-1:0] prod_reg
);

    logic [HALF_W-1:0] op_a;
    logic [HALF_W-1:0] op_b;

    assign sum = ctrl.sub ? (add_a - add_b) : (add_a + add_b);

    always_comb
    begin
        case (ctrl.part)
            MUL_LH:
            begin
                op_a = mul_x[HALF_W-1:0];
                op_b = mul_y[ACC_W-1:HALF_W];
            end
            MUL_HL:
            begin
                op_a = mul_x[ACC_W-1:HALF_W];
                op_b = mul_y[HALF_W-1:0];
            end
            default:
            begin
                op_a = mul_x[HALF_W-1:0];
                op_b = mul_y[HALF_W-1:0];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= ACC_W'(op_a) * ACC_W'(op_b);
    end

endmodule

// ===== hw/rtl/subset_convolution_engine_core.sv =====
// ----------------------------------------------------------------------------
// subset_convolution_engine_core
// Covering product and ranked subset convolution over subset-indexed tables.
// ----------------------------------------------------------------------------
// The in_ch channel carries one operation per transaction: load stores f and g
// at a subset, compute runs the selected product over the loaded tables, and
// read returns one result transaction on out_ch. The cfg channel writes
// set_bits and product_mode and is always ready; write it only while idle.
// A load writes the table memory when it is accepted. A read passes through
// ST_RD_WAIT, which registers the result memory output onto out_ch. A compute
// runs a sequencer over one shared adder and one 32x32 multiplier with a
// ranked memory of one read and one write port holding R rows of N entries
// per table, N = 2^n and R = n+1 in subset mode (R = 1 in covering mode).
// The input is not ready during a compute or a read, nor while a result
// waits on a stalled receiver. Reset clears control state only; table
// contents are undefined until written, and no clearing pass is run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module subset_convolution_engine_core import sce_pkg::*; #(
    parameter int MAX_BITS   = SCE_MAX_BITS,
    parameter int VALUE_BITS = SCE_VALUE_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    sce_in_if.sink    in_ch,
    sce_out_if.source out_ch,
    sce_cfg_if.sink   cfg
);

    localparam int SW       = MAX_BITS;
    localparam int KW       = $clog2(MAX_BITS + 1);
    localparam int BW       = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
    localparam int AW       = 2 + KW + SW;
    localparam int RK_DEPTH = 1 << AW;
    localparam int FT_DEPTH = 1 << SW;

    state_t                  state_reg, state_next;
    logic [2:0]              ph_reg, ph_next;
    logic [1:0]              arr_reg, arr_next;
    logic [KW-1:0]           k_reg, k_next;
    logic [KW-1:0]           j_reg, j_next;
    logic [BW-1:0]           b_reg, b_next;
    logic [SW-1:0]           s_reg, s_next;
    logic [ACC_W-1:0]        x_reg, x_next;
    logic [ACC_W-1:0]        y_reg, y_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic                    out_valid_reg, out_valid_next;
    logic [SW-1:0]           out_subset_reg, out_subset_next;
    logic [ACC_W-1:0]        out_value_reg, out_value_next;
    logic [SET_BITS_W-1:0]   set_bits_reg;
    logic                    mode_reg;

    logic [2*VALUE_BITS-1:0] ft_mem [FT_DEPTH];
    logic [2*VALUE_BITS-1:0] ft_q;
    logic                    ft_we;
    logic [SW-1:0]           ft_raddr;
    logic [SW-1:0]           ft_waddr;

    logic [ACC_W-1:0]        rk_mem [RK_DEPTH];
    logic [ACC_W-1:0]        rk_q;
    logic                    rk_we;
    logic [AW-1:0]           rk_raddr;
    logic [AW-1:0]           rk_waddr;
    logic [ACC_W-1:0]        rk_wdata;

    logic [ACC_W-1:0]        res_mem [FT_DEPTH];
    logic [ACC_W-1:0]        res_q;
    logic                    res_we;
    logic [SW-1:0]           res_raddr;

    alu_ctrl_t               alu_ctrl;
    logic [ACC_W-1:0]        alu_add_b;
    logic [ACC_W-1:0]        alu_sum;
    logic [ACC_W-1:0]        alu_prod;

    logic [SET_BITS_W-1:0]   n_act;
    logic [SW-1:0]           cnt_mask;
    logic [SW-1:0]           in_sub;
    logic [SW-1:0]           s_bit;
    logic [KW-1:0]           k_max;
    logic [KW-1:0]           s_rank;
    logic                    last_s;
    logic                    last_b;
    logic                    last_k;
    logic                    hit;
    logic                    in_fire;
    logic [ACC_W-1:0]        f_ext;
    logic [ACC_W-1:0]        g_ext;

    function automatic logic [KW-1:0] rank_of(input logic [SW-1:0] v);
        logic [KW-1:0] c;
        c = '0;
        for (int i = 0; i < SW; i++)
        begin
            c = c + KW'(v[i]);
        end
        return c;
    endfunction

    always_comb
    begin
        if (set_bits_reg == '0)
        begin
            n_act = SET_BITS_W'(1);
        end
        else if (set_bits_reg > SET_BITS_W'(MAX_BITS))
        begin
            n_act = SET_BITS_W'(MAX_BITS);
        end
        else
        begin
            n_act = set_bits_reg;
        end
        for (int i = 0; i < SW; i++)
        begin
            cnt_mask[i] = (i < int'(n_act));
        end
    end

    assign in_sub  = in_ch.subset & cnt_mask;
    assign s_bit   = SW'(1) << b_reg;
    assign k_max   = mode_reg ? KW'(n_act) : '0;
    assign s_rank  = rank_of(s_reg);
    assign last_s  = (s_reg == cnt_mask);
    assign last_b  = (b_reg == BW'(n_act - SET_BITS_W'(1)));
    assign last_k  = (k_reg == k_max);
    assign hit     = mode_reg ? (s_rank == k_reg) : 1'b1;
    assign f_ext   = ACC_W'($signed(ft_q[2*VALUE_BITS-1:VALUE_BITS]));
    assign g_ext   = ACC_W'($signed(ft_q[VALUE_BITS-1:0]));

    assign in_ch.ready = (state_reg == ST_IDLE) && !(out_valid_reg && !out_ch.ready);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign cfg.ready   = 1'b1;

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.out_subset = out_subset_reg;
    assign out_ch.value      = out_value_reg;

    assign ft_we     = in_fire && (in_ch.operation == OP_LOAD);
    assign ft_waddr  = in_sub;
    assign ft_raddr  = s_reg;
    assign res_raddr = in_sub;

    sce_alu u_alu (
        .clk      (clk),
        .ctrl     (alu_ctrl),
        .add_a    ((state_reg == ST_MUL) ? acc_reg : x_reg),
        .add_b    (alu_add_b),
        .mul_x    (x_reg),
        .mul_y    (y_reg),
        .sum      (alu_sum),
        .prod_reg (alu_prod)
    );

    always_comb
    begin
        state_next      = state_reg;
        ph_next         = ph_reg;
        arr_next        = arr_reg;
        k_next          = k_reg;
        j_next          = j_reg;
        b_next          = b_reg;
        s_next          = s_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        acc_next        = acc_reg;
        out_valid_next  = out_valid_reg;
        out_subset_next = out_subset_reg;
        out_value_next  = out_value_reg;
        rk_we           = 1'b0;
        rk_raddr        = {arr_reg, k_reg, s_reg};
        rk_waddr        = {arr_reg, k_reg, s_reg};
        rk_wdata        = alu_sum;
        res_we          = 1'b0;
        alu_ctrl.sub    = (arr_reg == ARR_P);
        alu_ctrl.part   = MUL_LL;
        alu_add_b       = rk_q;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_ch.operation == OP_COMPUTE)
                    begin
                        state_next = ST_INIT;
                        ph_next    = '0;
                        k_next     = '0;
                        s_next     = '0;
                    end
                    else if (in_ch.operation == OP_READ)
                    begin
                        state_next      = ST_RD_WAIT;
                        out_subset_next = in_sub;
                    end
                end
            end

            ST_RD_WAIT:
            begin
                out_value_next = res_q;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end

            ST_INIT:
            begin
                case (ph_reg)
                    3'd0:
                    begin
                        ph_next = 3'd1;
                    end
                    3'd1:
                    begin
                        rk_we    = 1'b1;
                        rk_waddr = {ARR_F, k_reg, s_reg};
                        rk_wdata = hit ? f_ext : '0;
                        ph_next  = 3'd2;
                    end
                    default:
                    begin
                        rk_we    = 1'b1;
                        rk_waddr = {ARR_G, k_reg, s_reg};
                        rk_wdata = hit ? g_ext : '0;
                        ph_next  = 3'd0;
                        if (last_s)
                        begin
                            s_next = '0;
                            if (last_k)
                            begin
                                k_next     = '0;
                                b_next     = '0;
                                arr_next   = ARR_F;
                                state_next = ST_ZETA;
                            end
                            else
                            begin
                                k_next = k_reg + KW'(1);
                            end
                        end
                        else
                        begin
                            s_next = s_reg + SW'(1);
                        end
                    end
                endcase
            end

            ST_ZETA:
            begin
                if (ph_reg == 3'd0 && (s_reg & s_bit) != '0)
                begin
                    ph_next = 3'd1;
                end
                else if (ph_reg == 3'd1)
                begin
                    x_next   = rk_q;
                    rk_raddr = {arr_reg, k_reg, s_reg ^ s_bit};
                    ph_next  = 3'd2;
                end
                else
                begin
                    if (ph_reg == 3'd2)
                    begin
                        rk_we = 1'b1;
                    end
                    ph_next = 3'd0;
                    if (last_s)
                    begin
                        s_next = '0;
                        if (last_b)
                        begin
                            b_next = '0;
                            if (last_k)
                            begin
                                k_next = '0;
                                if (arr_reg == ARR_F)
                                begin
                                    arr_next = ARR_G;
                                end
                                else if (arr_reg == ARR_G)
                                begin
                                    state_next = ST_MUL;
                                    j_next     = '0;
                                    acc_next   = '0;
                                end
                                else
                                begin
                                    state_next = ST_GATHER;
                                end
                            end
                            else
                            begin
                                k_next = k_reg + KW'(1);
                            end
                        end
                        else
                        begin
                            b_next = b_reg + BW'(1);
                        end
                    end
                    else
                    begin
                        s_next = s_reg + SW'(1);
                    end
                end
            end

            ST_MUL:
            begin
                alu_ctrl.sub = 1'b0;
                alu_add_b    = {alu_prod[HALF_W-1:0], HALF_W'(0)};
                case (ph_reg)
                    3'd0:
                    begin
                        rk_raddr = {ARR_F, j_reg, s_reg};
                        ph_next  = 3'd1;
                    end
                    3'd1:
                    begin
                        x_next   = rk_q;
                        rk_raddr = {ARR_G, k_reg - j_reg, s_reg};
                        ph_next  = 3'd2;
                    end
                    3'd2:
                    begin
                        y_next  = rk_q;
                        ph_next = 3'd3;
                    end
                    3'd3:
                    begin
                        alu_ctrl.part = MUL_LL;
                        ph_next       = 3'd4;
                    end
                    3'd4:
                    begin
                        alu_add_b     = alu_prod;
                        acc_next      = alu_sum;
                        alu_ctrl.part = MUL_LH;
                        ph_next       = 3'd5;
                    end
                    3'd5:
                    begin
                        acc_next      = alu_sum;
                        alu_ctrl.part = MUL_HL;
                        ph_next       = 3'd6;
                    end
                    3'd6:
                    begin
                        acc_next = alu_sum;
                        if (j_reg == k_reg)
                        begin
                            ph_next = 3'd7;
                        end
                        else
                        begin
                            j_next  = j_reg + KW'(1);
                            ph_next = 3'd0;
                        end
                    end
                    default:
                    begin
                        rk_we    = 1'b1;
                        rk_waddr = {ARR_P, k_reg, s_reg};
                        rk_wdata = acc_reg;
                        acc_next = '0;
                        j_next   = '0;
                        ph_next  = 3'd0;
                        if (last_s)
                        begin
                            s_next = '0;
                            if (last_k)
                            begin
                                k_next     = '0;
                                b_next     = '0;
                                arr_next   = ARR_P;
                                state_next = ST_ZETA;
                            end
                            else
                            begin
                                k_next = k_reg + KW'(1);
                            end
                        end
                        else
                        begin
                            s_next = s_reg + SW'(1);
                        end
                    end
                endcase
            end

            ST_GATHER:
            begin
                rk_raddr = {ARR_P, mode_reg ? s_rank : KW'(0), s_reg};
                if (ph_reg == 3'd0)
                begin
                    ph_next = 3'd1;
                end
                else
                begin
                    res_we  = 1'b1;
                    ph_next = 3'd0;
                    if (last_s)
                    begin
                        s_next     = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        s_next = s_reg + SW'(1);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ph_reg        <= '0;
            arr_reg       <= ARR_F;
            k_reg         <= '0;
            j_reg         <= '0;
            b_reg         <= '0;
            s_reg         <= '0;
            out_valid_reg <= 1'b0;
            set_bits_reg  <= SET_BITS_W'(8);
            mode_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ph_reg        <= ph_next;
            arr_reg       <= arr_next;
            k_reg         <= k_next;
            j_reg         <= j_next;
            b_reg         <= b_next;
            s_reg         <= s_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_SET_BITS)
                begin
                    set_bits_reg <= cfg.data[SET_BITS_W-1:0];
                end
                else if (cfg.index == REG_PRODUCT_MODE)
                begin
                    mode_reg <= cfg.data[0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        y_reg          <= y_next;
        acc_reg        <= acc_next;
        out_subset_reg <= out_subset_next;
        out_value_reg  <= out_value_next;
    end

    always_ff @(posedge clk)
    begin
        if (ft_we)
        begin
            ft_mem[ft_waddr] <= {in_ch.f_value, in_ch.g_value};
        end
        ft_q <= ft_mem[ft_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (rk_we)
        begin
            rk_mem[rk_waddr] <= rk_wdata;
        end
        rk_q <= rk_mem[rk_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (res_we)
        begin
            res_mem[s_reg] <= rk_q;
        end
        res_q <= res_mem[res_raddr];
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> (state_reg == ST_IDLE))
        else $error("input ready outside idle");

    a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_RD_WAIT))
        else $error("result raised without a read");

    a_mul_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (j_reg <= k_reg))
        else $error("product index past its row");

    a_zeta_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ZETA && ph_reg == 3'd2) |-> ((s_reg & s_bit) != '0))
        else $error("transform update on a subset without the bit");

endmodule
